// File: design/fasf_pkg.sv
// Shared types and constants for the approximate square root unit.
package fasf_pkg;

  localparam logic [31:0] MAGIC_WORD     = 32'h5f3759df;
  localparam logic [31:0] ONE_WORD       = 32'h3f800000;
  localparam logic [31:0] NEG_ZERO_WORD  = 32'h80000000;
  localparam logic [31:0] POS_INF_WORD   = 32'h7f800000;
  localparam logic [31:0] QUIET_BIT      = 32'h00400000;
  localparam logic [30:0] ONE_MAG        = 31'h3f800000;
  localparam logic [9:0]  EXP_BIAS       = 10'd127;
  localparam logic [23:0] MANT_ONE       = 24'h800000;

  // Divider layout: one quotient bit per step.
  localparam int DIV_STEPS       = 26;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

  // Positive normal number: biased exponent and significand with hidden bit.
  typedef struct packed {
    logic [7:0]  e;
    logic [23:0] m;
  } fnum_t;

  // Data that rides along with each item through the datapath.
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_word;
    fnum_t       est;
  } side_t;

endpackage

// File: design/fasf_operand_if.sv
// Input channel carrying the operand encoding.
interface fasf_operand_if;
  import fasf_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;
  modport source (output valid, output operand_bits, input ready);
  modport sink   (input valid, input operand_bits, output ready);
endinterface

// File: design/fasf_root_if.sv
// Output channel carrying the root encoding.
interface fasf_root_if;
  import fasf_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] root_bits;
  modport source (output valid, output root_bits, input ready);
  modport sink   (input valid, input root_bits, output ready);
endinterface

// File: design/fasf_mul.sv
// Two-stage single-precision multiplier for positive normal operands.
module fasf_mul
  import fasf_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  fnum_t a,
  input  fnum_t b,
  output fnum_t p
);

  logic [47:0] prod;
  logic [9:0]  esum;

  logic [23:0] m0;
  logic        g;
  logic        s;
  logic [9:0]  e0;
  logic [24:0] mr;
  fnum_t       p_next;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 48'(a.m) * 48'(b.m);
      esum <= {2'b00, a.e} + {2'b00, b.e} - EXP_BIAS;
    end
  end

  // Normalize by one place at most, then round to nearest even.
  always_comb begin
    if (prod[47]) begin
      m0 = prod[47:24];
      g  = prod[23];
      s  = |prod[22:0];
      e0 = esum + 10'd1;
    end else begin
      m0 = prod[46:23];
      g  = prod[22];
      s  = |prod[21:0];
      e0 = esum;
    end
    mr = {1'b0, m0} + 25'(g & (s | m0[0]));
    if (mr[24]) begin
      p_next.m = MANT_ONE;
      p_next.e = 8'(e0 + 10'd1);
    end else begin
      p_next.m = mr[23:0];
      p_next.e = e0[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_next;
    end
  end

endmodule

// File: design/fasf_recip.sv
// Pipelined restoring reciprocal with round to nearest even.
module fasf_recip
  import fasf_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  fnum_t y,
  output fnum_t r
);

  logic [24:0] rem [0:DIV_STAGES];
  logic [25:0] quo [0:DIV_STAGES];
  logic [23:0] dvs [0:DIV_STAGES];
  logic [7:0]  ye  [0:DIV_STAGES];

  // The dividend is one, scaled to the divisor's grid.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, MANT_ONE};
      quo[0] <= '0;
      dvs[0] <= y.m;
      ye[0]  <= y.e;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [24:0] r_c;
    logic [25:0] q_c;

    always_comb begin
      r_c = rem[k];
      q_c = quo[k];
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
        if (r_c >= {1'b0, dvs[k]}) begin
          q_c = {q_c[24:0], 1'b1};
          r_c = r_c - {1'b0, dvs[k]};
        end else begin
          q_c = {q_c[24:0], 1'b0};
        end
        r_c = {r_c[23:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= r_c;
        quo[k+1] <= q_c;
        dvs[k+1] <= dvs[k];
        ye[k+1]  <= ye[k];
      end
    end
  end

  logic [25:0] qf;
  logic [8:0]  ef;
  logic [24:0] mr;
  fnum_t       r_next;

  // A quotient of exactly one means the divisor was a power of two.
  always_comb begin
    qf = quo[DIV_STAGES];
    ef = 9'd253 - {1'b0, ye[DIV_STAGES]};
    mr = {1'b0, qf[24:1]} + 25'(qf[0] & ((|rem[DIV_STAGES]) | qf[1]));
    if (qf[25]) begin
      r_next.m = MANT_ONE;
      r_next.e = 8'(9'd254 - {1'b0, ye[DIV_STAGES]});
    end else if (mr[24]) begin
      r_next.m = MANT_ONE;
      r_next.e = 8'(ef + 9'd1);
    end else begin
      r_next.m = mr[23:0];
      r_next.e = ef[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= r_next;
    end
  end

endmodule

// File: design/fast_approx_sqrt_float_unit.sv
// Top level of the pipelined approximate square root unit.
//
//   channel   direction  payload              meaning
//   operand   in         operand_bits [31:0]  single-precision input encoding
//   result    out        root_bits    [31:0]  single-precision root encoding
//
// One item enters per cycle while the output slot is empty or drained;
// the divider resolves two quotient bits per stage.
// Reset clears only the per-stage valid bits; payload registers are not reset.
// No item is taken while reset is high.
// When the result is not taken, the whole pipeline holds in place, so no
// item is dropped or repeated; empty stages still fill while output is idle.
//
// Datapath: the input is halved and the magic estimate is formed, then two
// multiplies give (half * est) * est, a fixed-point subtract gives 1.5 - t,
// a third multiply gives y, and a restoring divider forms 1 / y. Inputs
// below one, NaNs and positive infinity are resolved at entry and ride along
// as a ready-made word. Every other input keeps all intermediates positive
// and normal, so the arithmetic units need no special-value handling.
module fast_approx_sqrt_float_unit
  import fasf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  fasf_operand_if.sink        operand,
  fasf_root_if.source         result
);

  localparam int LAST = 22;

  logic             en;
  logic [LAST:0]    vld;
  side_t            side [0:LAST];

  // The pipeline advances whenever the output slot is empty or drained.
  assign en            = !vld[LAST] || result.ready;
  assign operand.ready = en && !rst;

  // Entry classification.
  logic [31:0] raw;
  logic        is_nan;
  logic        lt_one;
  logic        is_pinf;
  logic [31:0] est_word;
  side_t       side_in;
  fnum_t       half;

  always_comb begin
    raw      = operand.operand_bits;
    is_nan   = (raw[30:23] == 8'hff) && (raw[22:0] != 23'd0);
    lt_one   = raw[31] ? !is_nan : (raw[30:0] < ONE_MAG);
    is_pinf  = (raw == POS_INF_WORD);
    est_word = MAGIC_WORD - {1'b0, raw[31:1]};

    side_in.spec  = lt_one || is_nan || is_pinf;
    if (lt_one) begin
      side_in.spec_word = ONE_WORD;
    end else if (is_nan) begin
      side_in.spec_word = raw | QUIET_BIT;
    end else begin
      // Infinity drives the correction to minus infinity; its reciprocal is -0.
      side_in.spec_word = NEG_ZERO_WORD;
    end
    side_in.est.e = est_word[30:23];
    side_in.est.m = {1'b1, est_word[22:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], operand.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      half.e  <= raw[30:23] - 8'd1;
      half.m  <= {1'b1, raw[22:0]};
      for (int i = 1; i <= LAST; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // t1 = half * est, lands with stage 2.
  fnum_t t1;
  fasf_mul u_mul_half (
    .clk (clk),
    .en  (en),
    .a   (half),
    .b   (side[0].est),
    .p   (t1)
  );

  // t = t1 * est, lands with stage 4.
  fnum_t t;
  fasf_mul u_mul_est (
    .clk (clk),
    .en  (en),
    .a   (t1),
    .b   (side[2].est),
    .p   (t)
  );

  // corr = 1.5 - t in fixed point with 25 fraction bits. t stays near one
  // half, so it is exact on this grid and corr stays near one.
  logic [26:0] tfix;
  logic [26:0] diff;
  logic [23:0] cm0;
  logic        cg;
  logic        cs;
  logic [7:0]  ce0;
  logic [24:0] cmr;
  fnum_t       corr_next;
  fnum_t       corr;

  always_comb begin
    if (t.e == 8'd126) begin
      tfix = {2'b00, t.m, 1'b0};
    end else begin
      tfix = {3'b000, t.m};
    end
    diff = 27'h3000000 - tfix;
    if (diff[25]) begin
      cm0 = diff[25:2];
      cg  = diff[1];
      cs  = diff[0];
      ce0 = 8'd127;
    end else begin
      cm0 = diff[24:1];
      cg  = diff[0];
      cs  = 1'b0;
      ce0 = 8'd126;
    end
    cmr = {1'b0, cm0} + 25'(cg & (cs | cm0[0]));
    if (cmr[24]) begin
      corr_next.m = MANT_ONE;
      corr_next.e = ce0 + 8'd1;
    end else begin
      corr_next.m = cmr[23:0];
      corr_next.e = ce0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corr <= corr_next;
    end
  end

  // y = est * corr, lands with stage 7.
  fnum_t y;
  fasf_mul u_mul_corr (
    .clk (clk),
    .en  (en),
    .a   (side[5].est),
    .b   (corr),
    .p   (y)
  );

  // r = 1 / y, lands with the last stage.
  fnum_t r;
  fasf_recip u_recip (
    .clk (clk),
    .en  (en),
    .y   (y),
    .r   (r)
  );

  assign result.valid     = vld[LAST];
  assign result.root_bits = side[LAST].spec ? side[LAST].spec_word
                                            : {1'b0, r.e, r.m[22:0]};

endmodule
